@@ hw/rtl/amo_pkg.sv @@
package amo_pkg;

	// store geometry
	localparam int ADDR_BITS   = 12;
	localparam int INDEX_BITS  = ADDR_BITS - 3;
	localparam int STORE_DEPTH = 2 ** INDEX_BITS;
	localparam int DATA_BITS   = 64;
	localparam int WORD_BITS   = 32;
	localparam int OP_BITS     = 4;

	// operation codes
	typedef enum logic [OP_BITS-1:0] {
		OP_LR   = 4'd0,
		OP_SC   = 4'd1,
		OP_SWAP = 4'd2,
		OP_ADD  = 4'd3,
		OP_XOR  = 4'd4,
		OP_AND  = 4'd5,
		OP_OR   = 4'd6,
		OP_MIN  = 4'd7,
		OP_MAX  = 4'd8,
		OP_MINU = 4'd9,
		OP_MAXU = 4'd10
	} op_t;

	// controller to datapath commands
	typedef struct packed {
		logic                  capture;
		logic                  exec;
		logic                  clear;
		logic [INDEX_BITS-1:0] clear_index;
	} amo_cmd_t;

endpackage

@@ hw/rtl/amo_ram.sv @@
module amo_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ hw/rtl/amo_ctrl.sv @@
module amo_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output amo_pkg::amo_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC
	} state_t;

	state_t                         state_q;
	logic [amo_pkg::INDEX_BITS-1:0] clear_cnt_q;
	logic                           out_valid_q;
	logic                           exec;

	// commands decoded from state
	assign in_ready  = (state_q == S_IDLE);
	assign exec      = (state_q == S_EXEC) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.capture     = in_valid && in_ready;
		cmd.exec        = exec;
		cmd.clear       = (state_q == S_CLEAR);
		cmd.clear_index = clear_cnt_q;
	end

	// state, clear sweep counter and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clear_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clear_cnt_q <= clear_cnt_q + amo_pkg::INDEX_BITS'(1);
					if (clear_cnt_q == amo_pkg::INDEX_BITS'(amo_pkg::STORE_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (exec) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (exec) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ hw/rtl/amo_dp.sv @@
module amo_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  amo_pkg::amo_cmd_t             cmd,
	input  logic [amo_pkg::OP_BITS-1:0]   operation,
	input  logic                          is_double,
	input  logic [amo_pkg::ADDR_BITS-1:0] byte_address,
	input  logic [amo_pkg::DATA_BITS-1:0] operand_value,
	output logic [amo_pkg::DATA_BITS-1:0] dest_value
);

	localparam int AB = amo_pkg::ADDR_BITS;
	localparam int DB = amo_pkg::DATA_BITS;
	localparam int WB = amo_pkg::WORD_BITS;

	amo_pkg::op_t      op_q;
	logic              dbl_q;
	logic [AB-1:0]     addr_q;
	logic [DB-1:0]     arg_q;
	logic              rsv_valid_q;
	logic [AB-1:0]     rsv_addr_q;
	logic [DB-1:0]     dest_q;

	logic [DB-1:0]     entry;
	logic [WB-1:0]     half;
	logic [DB-1:0]     old;
	logic [DB-1:0]     arg;
	logic [DB-1:0]     nv;
	logic [DB-1:0]     merged;
	logic [DB-1:0]     result;
	logic              sc_ok;
	logic              do_write;
	logic              ram_we;
	logic [AB-4:0]     ram_waddr;
	logic [DB-1:0]     ram_wdata;

	// item registers, address aligned to the access size
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= amo_pkg::op_t'(operation);
			dbl_q  <= is_double;
			addr_q <= {byte_address[AB-1:3], byte_address[2] & ~is_double, 2'b00};
			arg_q  <= operand_value;
		end
		if (cmd.exec) begin
			dest_q <= result;
		end
	end

	// store, read at capture and written at exec or by the clear sweep
	amo_ram #(
		.WIDTH(DB),
		.DEPTH(amo_pkg::STORE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.capture),
		.raddr(byte_address[AB-1:3]),
		.rdata(entry)
	);

	// operand selection and the operation itself
	always_comb begin
		half  = addr_q[2] ? entry[DB-1:WB] : entry[WB-1:0];
		old   = dbl_q ? entry : {{WB{half[WB-1]}}, half};
		arg   = dbl_q ? arg_q : {{WB{arg_q[WB-1]}}, arg_q[WB-1:0]};
		sc_ok = rsv_valid_q && (rsv_addr_q == addr_q);
		nv       = old;
		do_write = 1'b0;
		result   = '0;
		unique case (op_q)
			amo_pkg::OP_LR: begin
				result = old;
			end
			amo_pkg::OP_SC: begin
				nv       = arg;
				do_write = sc_ok;
				result   = {{(DB-1){1'b0}}, ~sc_ok};
			end
			amo_pkg::OP_SWAP: begin
				nv = arg; do_write = 1'b1; result = old;
			end
			amo_pkg::OP_ADD: begin
				nv = old + arg; do_write = 1'b1; result = old;
			end
			amo_pkg::OP_XOR: begin
				nv = old ^ arg; do_write = 1'b1; result = old;
			end
			amo_pkg::OP_AND: begin
				nv = old & arg; do_write = 1'b1; result = old;
			end
			amo_pkg::OP_OR: begin
				nv = old | arg; do_write = 1'b1; result = old;
			end
			amo_pkg::OP_MIN: begin
				nv = ($signed(arg) < $signed(old)) ? arg : old;
				do_write = 1'b1; result = old;
			end
			amo_pkg::OP_MAX: begin
				nv = ($signed(old) < $signed(arg)) ? arg : old;
				do_write = 1'b1; result = old;
			end
			amo_pkg::OP_MINU: begin
				nv = (arg < old) ? arg : old;
				do_write = 1'b1; result = old;
			end
			amo_pkg::OP_MAXU: begin
				nv = (old < arg) ? arg : old;
				do_write = 1'b1; result = old;
			end
			default: begin
				do_write = 1'b0;
			end
		endcase
		// word writes keep the other half of the entry
		if (dbl_q) begin
			merged = nv;
		end else if (addr_q[2]) begin
			merged = {nv[WB-1:0], entry[WB-1:0]};
		end else begin
			merged = {entry[DB-1:WB], nv[WB-1:0]};
		end
	end

	// write port shared by clear sweep and exec
	assign ram_we    = cmd.clear || (cmd.exec && do_write);
	assign ram_waddr = cmd.clear ? cmd.clear_index : addr_q[AB-1:3];
	assign ram_wdata = cmd.clear ? '0 : merged;

	// single reservation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsv_valid_q <= 1'b0;
			rsv_addr_q  <= '0;
		end else if (cmd.exec) begin
			if (op_q == amo_pkg::OP_LR) begin
				rsv_valid_q <= 1'b1;
				rsv_addr_q  <= addr_q;
			end else if (op_q == amo_pkg::OP_SC) begin
				rsv_valid_q <= 1'b0;
			end
		end
	end

	assign dest_value = dest_q;

endmodule

@@ hw/rtl/atomic_memory_op_unit.sv @@
// RV64A atomic unit over a local 64-bit store of amo_pkg::STORE_DEPTH entries (512 by
// default). After reset the block sweeps the store to zero, one entry a cycle, so in_ready
// stays low until the sweep is done. Each item is then first read from its store entry
// through the registered read port, then computed and written back through the single
// write port. The result sits in an output register, so the next item is accepted while
// the previous result waits to be taken; a stalled result holds off the write-back of the
// item behind it.
module atomic_memory_op_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [amo_pkg::OP_BITS-1:0]   operation,
	input  logic                          is_double,
	input  logic [amo_pkg::ADDR_BITS-1:0] byte_address,
	input  logic [amo_pkg::DATA_BITS-1:0] operand_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [amo_pkg::DATA_BITS-1:0] dest_value
);

	amo_pkg::amo_cmd_t cmd;

	// sequencing
	amo_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd      (cmd)
	);

	// store, alu and reservation
	amo_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.operation    (operation),
		.is_double    (is_double),
		.byte_address (byte_address),
		.operand_value(operand_value),
		.dest_value   (dest_value)
	);

endmodule

@@ hw/rtl/amo_checker.sv @@
module amo_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [amo_pkg::DATA_BITS-1:0] dest_value
);

	// one item in flight: no accept right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted while an item is in flight");

	// an accept into an empty output always yields a result, with no stall in between
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !out_valid) |-> ##2 out_valid)
		else $error("result missing two cycles after accept");

	// a new result only follows an accepted beat
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without an accepted beat");

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(dest_value)))
		else $error("stalled result beat changed");

endmodule

bind atomic_memory_op_unit amo_checker u_amo_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.dest_value(dest_value)
);
